/* hw/rtl/radial_gradient_pixel_defines.svh */
// assertion macros used by the checker file
`ifndef RADIAL_GRADIENT_PIXEL_DEFINES_SVH
`define RADIAL_GRADIENT_PIXEL_DEFINES_SVH

// concurrent assertion clocked on clk, held off while rst_n is low
`define RGP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// property checked on the cycle after the trigger
`define RGP_ASSERT_NEXT(name, clk, rst_n, trig, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("%m: assertion failed");

`endif

/* hw/rtl/rgp_pkg.sv */
package rgp_pkg;

  localparam int unsigned COORD_W = 11;
  localparam int unsigned OFS_W   = 12;
  localparam logic [OFS_W-1:0] IMAGE_SIDE = 12'd2048;
  localparam int unsigned NORM_W  = 24;
  // q = (dx^2 + dy^2) * 2^32 / 2^24, exact since the side is a power of two
  localparam int unsigned NORM_SHIFT = 8;
  localparam int unsigned RAD_W   = 32;
  localparam int unsigned ROOT_W  = 16;
  localparam int unsigned REM_W   = ROOT_W + 1;
  localparam int unsigned LVL_W   = 16;
  localparam int unsigned QUO_W   = LVL_W + 1;
  localparam int unsigned NUM_CH  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned CH_BLUE  = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_RED   = 2;

  localparam logic [LVL_W-1:0] BLUE_SPREAD_RST  = 16'd46341;
  localparam logic [LVL_W-1:0] GREEN_SPREAD_RST = 16'd16384;
  localparam logic [LVL_W-1:0] RED_SPREAD_RST   = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLUE_SPREAD  = 2'd0,
    REG_GREEN_SPREAD = 2'd1,
    REG_RED_SPREAD   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

/* hw/rtl/rgp_sqrt.sv */
module rgp_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rgp_pkg::pipe_ctl_t             ctl_i,
  input  logic [rgp_pkg::RAD_W-1:0]      rad_i,
  output logic                           valid_o,
  output logic [rgp_pkg::ROOT_W-1:0]     root_o
);

  localparam int unsigned N   = rgp_pkg::ROOT_W;
  localparam int unsigned RW  = rgp_pkg::REM_W;
  localparam int unsigned CW  = RW + 2;

  logic                        vld_q  [N];
  logic [RW-1:0]               rem_q  [N];
  logic [N-1:0]                root_q [N];
  logic [rgp_pkg::RAD_W-1:0]   rad_q  [N];

  // one root digit per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    logic                      v_prev;
    logic [RW-1:0]             rem_prev;
    logic [N-1:0]              root_prev;
    logic [rgp_pkg::RAD_W-1:0] rad_prev;
    logic [CW-1:0]             cur;
    logic [CW-1:0]             trial;
    logic [RW-1:0]             rem_d;
    logic [N-1:0]              root_d;

    if (i == 0) begin : g_first
      assign v_prev    = ctl_i.valid;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign rad_prev  = rad_i;
    end else begin : g_next
      assign v_prev    = vld_q[i-1];
      assign rem_prev  = rem_q[i-1];
      assign root_prev = root_q[i-1];
      assign rad_prev  = rad_q[i-1];
    end

    always_comb begin
      cur   = {rem_prev, rad_prev[rgp_pkg::RAD_W-1 -: 2]};
      trial = {1'b0, root_prev, 2'b01};
      if (cur >= trial) begin
        rem_d  = RW'(cur - trial);
        root_d = {root_prev[N-2:0], 1'b1};
      end else begin
        rem_d  = cur[RW-1:0];
        root_d = {root_prev[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[i] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[i]  <= rem_d;
        root_q[i] <= root_d;
        rad_q[i]  <= rad_prev << 2;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];

endmodule

/* hw/rtl/rgp_div.sv */
module rgp_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rgp_pkg::pipe_ctl_t             ctl_i,
  input  logic [rgp_pkg::ROOT_W-1:0]     dist_i,
  input  logic [rgp_pkg::LVL_W-1:0]      spread_i [rgp_pkg::NUM_CH],
  output logic                           valid_o,
  output logic [rgp_pkg::LVL_W-1:0]      level_o  [rgp_pkg::NUM_CH]
);

  localparam int unsigned N  = rgp_pkg::QUO_W;
  localparam int unsigned C  = rgp_pkg::NUM_CH;
  localparam int unsigned LW = rgp_pkg::LVL_W;

  logic          vld_q  [N];
  logic [LW-1:0] rem_q  [N][C];
  logic [N-1:0]  quo_q  [N][C];
  logic          kill_q [N][C];

  // one quotient bit per stage, all channels side by side
  for (genvar i = 0; i < N; i++) begin : g_step
    logic v_prev;

    if (i == 0) begin : g_first
      assign v_prev = ctl_i.valid;
    end else begin : g_next
      assign v_prev = vld_q[i-1];
    end

    for (genvar c = 0; c < C; c++) begin : g_ch
      logic [LW:0]   cur;
      logic [N-1:0]  quo_prev;
      logic          kill_prev;
      logic          qbit;

      if (i == 0) begin : g_first
        assign cur       = {1'b0, spread_i[c]} - {1'b0, dist_i};
        assign quo_prev  = '0;
        assign kill_prev = dist_i > spread_i[c];
      end else begin : g_next
        assign cur       = {rem_q[i-1][c], 1'b0};
        assign quo_prev  = quo_q[i-1][c];
        assign kill_prev = kill_q[i-1][c];
      end

      assign qbit = cur >= {1'b0, spread_i[c]};

      always_ff @(posedge clk_i) begin
        if (ctl_i.en) begin
          rem_q[i][c]  <= qbit ? LW'(cur - {1'b0, spread_i[c]}) : cur[LW-1:0];
          quo_q[i][c]  <= {quo_prev[N-2:0], qbit};
          kill_q[i][c] <= kill_prev;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[i] <= v_prev;
      end
    end
  end

  assign valid_o = vld_q[N-1];

  // beyond the spread gives zero, a full quotient saturates
  for (genvar c = 0; c < C; c++) begin : g_lvl
    always_comb begin
      if (kill_q[N-1][c]) begin
        level_o[c] = '0;
      end else if (quo_q[N-1][c][N-1]) begin
        level_o[c] = '1;
      end else begin
        level_o[c] = quo_q[N-1][c][LW-1:0];
      end
    end
  end

endmodule

/* hw/rtl/radial_gradient_pixel.sv */
// radial gradient pixel: one (row, col) transfer in, one (blue, green, red) level transfer
// out, one pixel per clock while the output is not stalled. the stages are one offset
// stage, one squaring stage, 16 square-root stages (one root bit each) and 17 divider
// stages (one quotient bit each, three channels in parallel), then the output register.
// the whole pipeline advances together whenever the output register is empty or being
// taken, so in_stall_o follows out_stall_i only while a result sits in the output
// register. image side is 2048 and levels are Q0.16. the user writes spreads through the cfg
// port (index 0 blue, 1 green, 2 red, others ignored) only while the pipeline is empty, unchecked.
module radial_gradient_pixel (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rgp_pkg::COORD_W-1:0]        pixel_row_i,
  input  logic [rgp_pkg::COORD_W-1:0]        pixel_col_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rgp_pkg::LVL_W-1:0]          blue_level_o,
  output logic [rgp_pkg::LVL_W-1:0]          green_level_o,
  output logic [rgp_pkg::LVL_W-1:0]          red_level_o,
  input  logic                               cfg_we_i,
  input  logic [rgp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rgp_pkg::LVL_W-1:0]          cfg_data_i
);

  localparam int unsigned OW = rgp_pkg::OFS_W;
  localparam int unsigned XW = rgp_pkg::NORM_W - OW;

  // spread registers
  logic [rgp_pkg::LVL_W-1:0] spread_q [rgp_pkg::NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_q[rgp_pkg::CH_BLUE]  <= rgp_pkg::BLUE_SPREAD_RST;
      spread_q[rgp_pkg::CH_GREEN] <= rgp_pkg::GREEN_SPREAD_RST;
      spread_q[rgp_pkg::CH_RED]   <= rgp_pkg::RED_SPREAD_RST;
    end else if (cfg_we_i) begin
      unique case (rgp_pkg::cfg_idx_e'(cfg_idx_i))
        rgp_pkg::REG_BLUE_SPREAD:  spread_q[rgp_pkg::CH_BLUE]  <= cfg_data_i;
        rgp_pkg::REG_GREEN_SPREAD: spread_q[rgp_pkg::CH_GREEN] <= cfg_data_i;
        rgp_pkg::REG_RED_SPREAD:   spread_q[rgp_pkg::CH_RED]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: output register empty or being taken
  logic               out_valid_q;
  rgp_pkg::pipe_ctl_t ctl;
  assign ctl.en      = !out_valid_q || !out_stall_i;
  assign ctl.valid   = in_valid_i;
  assign in_stall_o  = !ctl.en;

  // half-pixel offsets from the centre; 11-bit coords never reach the side, so no clamp
  function automatic logic [OW-1:0] abs_ofs(input logic [rgp_pkg::COORD_W-1:0] c);
    logic [OW-1:0] twice;
    twice = {c, 1'b0};
    return (twice >= rgp_pkg::IMAGE_SIDE) ? twice - rgp_pkg::IMAGE_SIDE
                                          : rgp_pkg::IMAGE_SIDE - twice;
  endfunction

  logic          ofs_vld_q;
  logic [OW-1:0] dx_q, dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_vld_q <= 1'b0;
    end else if (ctl.en) begin
      ofs_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en) begin
      dx_q <= abs_ofs(pixel_col_i);
      dy_q <= abs_ofs(pixel_row_i);
    end
  end

  // squared radius, fits in 24 bits since each offset is at most 2048
  logic                       sq_vld_q;
  logic [rgp_pkg::NORM_W-1:0] norm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else if (ctl.en) begin
      sq_vld_q <= ofs_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en) begin
      norm_q <= {{XW{1'b0}}, dx_q} * {{XW{1'b0}}, dx_q}
              + {{XW{1'b0}}, dy_q} * {{XW{1'b0}}, dy_q};
    end
  end

  // distance as Q0.16 fraction of the side
  rgp_pkg::pipe_ctl_t         sqrt_ctl;
  logic                       dist_vld;
  logic [rgp_pkg::ROOT_W-1:0] dist_root;

  assign sqrt_ctl.en    = ctl.en;
  assign sqrt_ctl.valid = sq_vld_q;

  rgp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sqrt_ctl),
    .rad_i   ({norm_q, {rgp_pkg::NORM_SHIFT{1'b0}}}),
    .valid_o (dist_vld),
    .root_o  (dist_root)
  );

  // per-channel falloff: (spread - distance) / spread
  rgp_pkg::pipe_ctl_t        div_ctl;
  logic                      lvl_vld;
  logic [rgp_pkg::LVL_W-1:0] level [rgp_pkg::NUM_CH];

  assign div_ctl.en    = ctl.en;
  assign div_ctl.valid = dist_vld;

  rgp_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (div_ctl),
    .dist_i   (dist_root),
    .spread_i (spread_q),
    .valid_o  (lvl_vld),
    .level_o  (level)
  );

  // output register
  logic [rgp_pkg::LVL_W-1:0] blue_q, green_q, red_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.en) begin
      out_valid_q <= lvl_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en) begin
      blue_q  <= level[rgp_pkg::CH_BLUE];
      green_q <= level[rgp_pkg::CH_GREEN];
      red_q   <= level[rgp_pkg::CH_RED];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign blue_level_o  = blue_q;
  assign green_level_o = green_q;
  assign red_level_o   = red_q;

endmodule

/* hw/rtl/rgp_checker.sv */
`include "radial_gradient_pixel_defines.svh"

module rgp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rgp_pkg::LVL_W-1:0]     blue_level_o,
  input logic [rgp_pkg::LVL_W-1:0]     green_level_o,
  input logic [rgp_pkg::LVL_W-1:0]     red_level_o
);

  // a held result stays put
  `RGP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(blue_level_o) && $stable(green_level_o) && $stable(red_level_o))

  // input is held off only behind a waiting result
  `RGP_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o == (out_valid_o && out_stall_i))

  // an empty output never blocks the input
  `RGP_ASSERT(a_no_idle_stall, clk_i, rst_ni, !out_valid_o |-> !in_stall_o)

endmodule

bind radial_gradient_pixel rgp_checker u_rgp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .blue_level_o  (blue_level_o),
  .green_level_o (green_level_o),
  .red_level_o   (red_level_o)
);

/* bench/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rgp_pkg::*;

  // index 3 is not a register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int unsigned          DRAIN_CYCLES = 48;

  typedef struct packed {
    logic [LVL_W-1:0] blue;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] red;
  } levels_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [COORD_W-1:0]   pixel_row_i = '0;
  logic [COORD_W-1:0]   pixel_col_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [LVL_W-1:0]     blue_level_o;
  logic [LVL_W-1:0]     green_level_o;
  logic [LVL_W-1:0]     red_level_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [LVL_W-1:0]     cfg_data_i = '0;

  radial_gradient_pixel u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .pixel_row_i, .pixel_col_i,
    .out_valid_o, .out_stall_i, .blue_level_o, .green_level_o, .red_level_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // own copy of the spreads, changed only while the pipeline is empty
  logic [LVL_W-1:0] blue_spread_q  = BLUE_SPREAD_RST;
  logic [LVL_W-1:0] green_spread_q = GREEN_SPREAD_RST;
  logic [LVL_W-1:0] red_spread_q   = RED_SPREAD_RST;

  levels_t pending_levels[$];
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned pixels_seen = 0;
  int unsigned cfg_writes = 0;
  bit quiet = 1'b0;   // no idling on either side while set

  function automatic logic [ROOT_W-1:0] root_floor(input logic [RAD_W-1:0] v);
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] root;
    logic [RAD_W-1:0] bitv;
    rem = v;
    root = '0;
    bitv = 32'h4000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[ROOT_W-1:0];
  endfunction

  function automatic logic [LVL_W-1:0] falloff(input logic [ROOT_W-1:0] distance,
                                               input logic [LVL_W-1:0] spread);
    logic [47:0] quo;
    if (distance > spread) return '0;
    if (spread == 0) return 16'hFFFF;
    quo = ({32'd0, spread - distance} << 16) / {32'd0, spread};
    return (quo > 48'hFFFF) ? 16'hFFFF : quo[LVL_W-1:0];
  endfunction

  // offsets in half pixels, distance as Q0.16 fraction of the side
  function automatic levels_t gradient_levels(input logic [COORD_W-1:0] row,
                                              input logic [COORD_W-1:0] col);
    logic [OFS_W:0] dx, dy;
    logic [RAD_W-1:0] dist_sq;
    logic [ROOT_W-1:0] distance;
    levels_t lv;
    dx = ({1'b0, col, 1'b0} >= 13'd2048) ? {1'b0, col, 1'b0} - 13'd2048
                                          : 13'd2048 - {1'b0, col, 1'b0};
    dy = ({1'b0, row, 1'b0} >= 13'd2048) ? {1'b0, row, 1'b0} - 13'd2048
                                          : 13'd2048 - {1'b0, row, 1'b0};
    dist_sq = ({19'd0, dx} * {19'd0, dx} + {19'd0, dy} * {19'd0, dy}) << NORM_SHIFT;
    distance = root_floor(dist_sq);
    lv.blue  = falloff(distance, blue_spread_q);
    lv.green = falloff(distance, green_spread_q);
    lv.red   = falloff(distance, red_spread_q);
    return lv;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  // one pixel transfer; valid stays high when the next one follows with no gap
  task automatic send_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_row_i <= row;
    pixel_col_i <= col;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_levels.push_back(gradient_levels(row, col));
    pixels_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write with the pipeline drained
  task automatic write_spread(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] val);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BLUE_SPREAD:  blue_spread_q  = val;
      REG_GREEN_SPREAD: green_spread_q = val;
      REG_RED_SPREAD:   red_spread_q   = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic write_all(input logic [LVL_W-1:0] b, input logic [LVL_W-1:0] g,
                           input logic [LVL_W-1:0] r);
    write_spread(REG_BLUE_SPREAD, b);
    write_spread(REG_GREEN_SPREAD, g);
    write_spread(REG_RED_SPREAD, r);
  endtask

  // receiver side: random stall per result, checking of every output transfer
  int stall_left = 0;
  always @(posedge clk_i) begin
    levels_t want;
    if (out_valid_o && !out_stall_i) begin
      pixels_seen++;
      if (pending_levels.size() == 0) begin
        $display("unexpected result transfer at %0t", $realtime);
        mismatches++;
      end else begin
        want = pending_levels.pop_front();
        if (blue_level_o !== want.blue) report_mismatch("blue", want.blue, blue_level_o);
        if (green_level_o !== want.green) report_mismatch("green", want.green, green_level_o);
        if (red_level_o !== want.red) report_mismatch("red", want.red, red_level_o);
      end
      stall_left = quiet ? 0 : $urandom_range(0, 15);
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // corners, edges, center and alternating bit patterns
  task automatic test_reset_spreads();
    send_pixel(11'd1024, 11'd1024);
    send_pixel(11'd0, 11'd0);
    send_pixel(11'd2047, 11'd2047);
    send_pixel(11'd0, 11'd2047);
    send_pixel(11'd2047, 11'd0);
    send_pixel(11'd1024, 11'd0);
    send_pixel(11'd0, 11'd1024);
    send_pixel(11'h555, 11'h2AA);
    send_pixel(11'h2AA, 11'h555);
    send_pixel(11'd1023, 11'd1025);
    // floored distance exactly at the green spread of 0.25
    send_pixel(11'd1024, 11'd1536);
  endtask

  task automatic test_zero_spread();
    write_all(16'd0, 16'd0, 16'd0);
    send_pixel(11'd1024, 11'd1024);
    send_pixel(11'd1024, 11'd1025);
    send_pixel(11'd0, 11'd0);
  endtask

  task automatic test_full_spread();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(11'd1024, 11'd1024);
    send_pixel(11'd0, 11'd0);
    send_pixel(11'd2047, 11'd1024);
  endtask

  // spread just below, at and above the distance 16384 of (1024, 1536)
  task automatic test_spread_edge();
    write_all(16'd16383, 16'd16384, 16'd16385);
    send_pixel(11'd1024, 11'd1536);
    send_pixel(11'd1536, 11'd1024);
    write_all(16'd1, 16'd2, 16'd65534);
    send_pixel(11'd1024, 11'd1024);
    send_pixel(11'd1024, 11'd1023);
  endtask

  // a write to the unused index must leave all spreads alone
  task automatic test_unused_index();
    write_all(16'd20000, 16'd30000, 16'd40000);
    write_spread(REG_NONE, 16'h0000);
    write_spread(REG_NONE, 16'hFFFF);
    send_pixel(11'd1200, 11'd900);
    send_pixel(11'd100, 11'd1900);
  endtask

  task automatic test_random_pixels();
    logic [COORD_W-1:0] row, col;
    for (int phase = 0; phase < 8; phase++) begin
      write_all(LVL_W'($urandom_range(0, 65535)), LVL_W'($urandom_range(0, 65535)),
                LVL_W'($urandom_range(0, 65535)));
      quiet = (phase % 3 == 2);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          row = COORD_W'(32'd992 + $urandom_range(0, 64));
          col = COORD_W'(32'd992 + $urandom_range(0, 64));
        end else begin
          row = COORD_W'($urandom_range(0, 2047));
          col = COORD_W'($urandom_range(0, 2047));
        end
        send_pixel(row, col);
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_spreads();
    test_zero_spread();
    test_full_spread();
    test_spread_edge();
    test_unused_index();
    test_random_pixels();
    settle();
    $display("sent %0d pixels, checked %0d results, %0d register writes",
             pixels_sent, pixels_seen, cfg_writes);
    $display("covered corners, center, zero and full spreads, spread edges, unused index");
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d results outstanding", pending_levels.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
